FILE: hw/rtl/idle_timeout_wheel_unit_macros.svh
`ifndef IDLE_TIMEOUT_WHEEL_UNIT_MACROS_SVH
`define IDLE_TIMEOUT_WHEEL_UNIT_MACROS_SVH

`ifndef SYNTH
`define ITW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ITW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ITW_ASSERT_NOW(lbl, ante, cons)
`define ITW_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/itw_pkg.sv
package itw_pkg;

	localparam int WHEEL_SLOTS = 8;
	localparam int MAX_CONN = 64;

	localparam int ID_W = 6;
	localparam int DATA_W = ((ID_W + 7) / 8) * 8;
	localparam int SLOT_W = (WHEEL_SLOTS > 2) ? $clog2(WHEEL_SLOTS) : 1;
	localparam int ADDR_W = (MAX_CONN > 2) ? $clog2(MAX_CONN) : 1;
	localparam int CNT_W = $clog2(MAX_CONN + 1);

	localparam logic CMD_TOUCH = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic valid;
		logic [ID_W-1:0] id;
		logic last;
	} push_t;

endpackage

FILE: hw/rtl/idle_timeout_wheel_unit.sv
// idle connection timing wheel
// input stream s_axis: tuser[0] is the command (0 touch, 1 tick), tdata[5:0]
// the connection id. a touch records the id in the current slot (moving it
// if it was held elsewhere); ids at or above the table size are ignored.
// a tick advances the slot pointer and reports every id held in the new
// slot on m_axis, ascending, tlast on the final one, and frees those ids.
// a touch leaves the block idle, so touches can stream back to back.
// a tick holds off new requests until its scan and flush are through:
// the slot table sits in one memory with one read port and the scan reads
// one entry per cycle while m_axis does not stall.
// each hit is held until the next hit or the end of the scan settles tlast,
// so an expired id shows on m_axis only once the next hit or the end of
// the scan has come.
// a full output register with tready low holds the scan until it drains;
// no new request is taken until the scan and its last result are handed on.
// reset clears the slot pointer and the per-id valid flops at once, so the
// block is ready right after reset with no clearing pass; the output
// register empties.
`include "idle_timeout_wheel_unit_macros.svh"

module idle_timeout_wheel_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [itw_pkg::DATA_W-1:0]  s_axis_tdata,  // conn_id
	input  logic [0:0]                  s_axis_tuser,  // cmd
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [itw_pkg::DATA_W-1:0]  m_axis_tdata,  // expired_id
	output logic                        m_axis_tlast
);

	itw_pkg::state_t state_q, state_d;

	logic [itw_pkg::SLOT_W-1:0]   cur_q;
	logic [itw_pkg::MAX_CONN-1:0] vld_q;
	logic [itw_pkg::CNT_W-1:0]    cnt_q;
	logic                         scan_vld_s1;
	logic [itw_pkg::ADDR_W-1:0]   scan_idx_s1;
	logic                         pend_vld_q;
	logic [itw_pkg::ADDR_W-1:0]   pend_idx_q;

	logic [itw_pkg::ID_W-1:0]   conn_id;
	logic                       in_acc;
	logic                       id_ok;
	logic                       touch_we;
	logic                       tick;
	logic [itw_pkg::SLOT_W-1:0] cur_next;
	logic [itw_pkg::SLOT_W-1:0] rd_data;
	logic [itw_pkg::ADDR_W-1:0] rd_addr;
	logic                       match;
	logic                       stall;
	logic                       issue;
	logic                       scan_done;
	logic                       out_free;
	itw_pkg::push_t             push;

	assign conn_id = s_axis_tdata[itw_pkg::ID_W-1:0];
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign id_ok = {1'b0, conn_id} < (itw_pkg::ID_W + 1)'(itw_pkg::MAX_CONN);
	assign touch_we = in_acc && (s_axis_tuser[0] == itw_pkg::CMD_TOUCH) && id_ok;
	assign tick = in_acc && (s_axis_tuser[0] == itw_pkg::CMD_TICK);
	assign cur_next = (cur_q == itw_pkg::SLOT_W'(itw_pkg::WHEEL_SLOTS - 1)) ?
		'0 : cur_q + 1'b1;

	assign match = scan_vld_s1 && vld_q[scan_idx_s1] && (rd_data == cur_q);
	assign stall = match && pend_vld_q && !out_free;
	assign issue = (state_q == itw_pkg::ST_SCAN) &&
		(cnt_q < itw_pkg::CNT_W'(itw_pkg::MAX_CONN));
	assign scan_done = (state_q == itw_pkg::ST_SCAN) && !scan_vld_s1 && !issue;
	assign rd_addr = stall ? scan_idx_s1 : cnt_q[itw_pkg::ADDR_W-1:0];

	itw_slot_ram #(
		.DEPTH(itw_pkg::MAX_CONN),
		.AW(itw_pkg::ADDR_W),
		.DW(itw_pkg::SLOT_W)
	) u_ram (
		.clk(clk),
		.we(touch_we),
		.waddr(conn_id[itw_pkg::ADDR_W-1:0]),
		.wdata(cur_q),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	itw_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.free(out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			itw_pkg::ST_IDLE: begin
				if (tick) begin
					state_d = itw_pkg::ST_SCAN;
				end
			end
			itw_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = itw_pkg::ST_FLUSH;
				end
			end
			itw_pkg::ST_FLUSH: begin
				if (!pend_vld_q || out_free) begin
					state_d = itw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itw_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		push.valid = 1'b0;
		push.id = itw_pkg::ID_W'(pend_idx_q);
		push.last = 1'b0;
		case (state_q)
			itw_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			itw_pkg::ST_SCAN: begin
				// a new hit shows the held one was not the last
				push.valid = match && pend_vld_q && out_free;
			end
			itw_pkg::ST_FLUSH: begin
				push.valid = pend_vld_q && out_free;
				push.last = 1'b1;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itw_pkg::ST_IDLE;
			cur_q <= '0;
			vld_q <= '0;
			cnt_q <= '0;
			scan_vld_s1 <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tick) begin
				cur_q <= cur_next;
				cnt_q <= '0;
			end else if (issue && !stall) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (touch_we) begin
				vld_q[conn_id[itw_pkg::ADDR_W-1:0]] <= 1'b1;
			end else if (match && !stall) begin
				vld_q[scan_idx_s1] <= 1'b0;
			end
			if (!stall) begin
				scan_vld_s1 <= issue;
			end
			if (match && !stall) begin
				pend_vld_q <= 1'b1;
			end else if ((state_q == itw_pkg::ST_FLUSH) && out_free) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue && !stall) begin
			scan_idx_s1 <= cnt_q[itw_pkg::ADDR_W-1:0];
		end
		if (match && !stall) begin
			pend_idx_q <= scan_idx_s1;
		end
	end

	`ITW_ASSERT_NOW(a_idle_no_pend, state_q == itw_pkg::ST_IDLE, !pend_vld_q && !scan_vld_s1)
	`ITW_ASSERT_NXT(a_tick_starts_scan, tick, state_q == itw_pkg::ST_SCAN && cnt_q == '0)
	`ITW_ASSERT_NXT(a_hit_clears_valid, match && !stall, !vld_q[$past(scan_idx_s1)])
	`ITW_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= itw_pkg::CNT_W'(itw_pkg::MAX_CONN))
	`ITW_ASSERT_NOW(a_last_only_flush, push.valid && push.last, state_q == itw_pkg::ST_FLUSH)

endmodule

FILE: hw/rtl/itw_slot_ram.sv
module itw_slot_ram #(
	parameter int DEPTH = 64,
	parameter int AW = 6,
	parameter int DW = 3
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/itw_out_stage.sv
module itw_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  itw_pkg::push_t              push,
	output logic                        free,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [itw_pkg::DATA_W-1:0]  m_axis_tdata,
	output logic                        m_axis_tlast
);

	logic                     vld_q;
	logic [itw_pkg::ID_W-1:0] id_q;
	logic                     last_q;

	assign free = !vld_q || m_axis_tready;
	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = itw_pkg::DATA_W'(id_q);
	assign m_axis_tlast = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (push.valid) begin
			vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			id_q <= push.id;
			last_q <= push.last;
		end
	end

endmodule

FILE: tb/idle_timeout_wheel_unit_tb.sv
`timescale 1ns / 1ps

module idle_timeout_wheel_unit_tb;

	localparam int USE_MODEL = -1;
	localparam int PLAN_ROWS = 19;
	localparam int RANDOM_REQS = 400;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [itw_pkg::ID_W-1:0] id;
		logic last;
	} expiry_t;

	typedef struct {
		logic cmd;
		logic [itw_pkg::ID_W-1:0] id;
		int n_typed;
		logic [itw_pkg::ID_W-1:0] first_id;
		logic [itw_pkg::ID_W-1:0] second_id;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [itw_pkg::DATA_W-1:0] s_axis_tdata;  // conn_id
	logic [0:0] s_axis_tuser;  // cmd
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [itw_pkg::DATA_W-1:0] m_axis_tdata;  // expired_id
	logic m_axis_tlast;

	idle_timeout_wheel_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// slot pointer starts at 0, so the first tick lands on slot 1
	plan_row_t plan[PLAN_ROWS] = '{
		'{itw_pkg::CMD_TICK, 6'd0, 0, 6'd0, 6'd0},
		'{itw_pkg::CMD_TOUCH, 6'd0, 0, 6'd0, 6'd0},
		'{itw_pkg::CMD_TOUCH, 6'd63, 0, 6'd0, 6'd0},
		'{itw_pkg::CMD_TOUCH, 6'd21, 0, 6'd0, 6'd0},
		'{itw_pkg::CMD_TICK, 6'd0, 0, 6'd0, 6'd0},
		'{itw_pkg::CMD_TOUCH, 6'd21, 0, 6'd0, 6'd0},
		'{itw_pkg::CMD_TOUCH, 6'd42, 0, 6'd0, 6'd0},
		'{itw_pkg::CMD_TICK, 6'd63, USE_MODEL, 6'd0, 6'd0},
		'{itw_pkg::CMD_TICK, 6'd0, USE_MODEL, 6'd0, 6'd0},
		'{itw_pkg::CMD_TICK, 6'd42, USE_MODEL, 6'd0, 6'd0},
		'{itw_pkg::CMD_TICK, 6'd0, USE_MODEL, 6'd0, 6'd0},
		'{itw_pkg::CMD_TICK, 6'd21, USE_MODEL, 6'd0, 6'd0},
		'{itw_pkg::CMD_TICK, 6'd0, USE_MODEL, 6'd0, 6'd0},
		'{itw_pkg::CMD_TICK, 6'd0, 2, 6'd0, 6'd63},
		'{itw_pkg::CMD_TICK, 6'd0, 2, 6'd21, 6'd42},
		'{itw_pkg::CMD_TOUCH, 6'd5, 0, 6'd0, 6'd0},
		'{itw_pkg::CMD_TOUCH, 6'd5, 0, 6'd0, 6'd0},
		'{itw_pkg::CMD_TICK, 6'd0, USE_MODEL, 6'd0, 6'd0},
		'{itw_pkg::CMD_TOUCH, 6'd5, USE_MODEL, 6'd0, 6'd0}
	};

	logic [itw_pkg::SLOT_W-1:0] wheel_pos;
	bit held[itw_pkg::MAX_CONN];
	logic [itw_pkg::SLOT_W-1:0] held_slot[itw_pkg::MAX_CONN];

	expiry_t due_expiries[$];
	logic [itw_pkg::ID_W-1:0] recent_ids[$];
	int errors;
	int reqs_sent;
	int touches;
	int ticks;
	int expiries_seen;
	int widest_burst;
	bit calm;
	bit hold_req;

	function automatic void wheel_step(input logic c, input logic [itw_pkg::ID_W-1:0] id,
			output expiry_t res[$]);
		int next_pos;
		res.delete();
		if (c == itw_pkg::CMD_TOUCH) begin
			if (int'(id) < itw_pkg::MAX_CONN) begin
				held[id] = 1'b1;
				held_slot[id] = wheel_pos;
			end
		end else begin
			next_pos = (int'(wheel_pos) + 1) % itw_pkg::WHEEL_SLOTS;
			wheel_pos = itw_pkg::SLOT_W'(next_pos);
			for (int i = 0; i < itw_pkg::MAX_CONN; i++) begin
				if (held[i] && held_slot[i] == wheel_pos) begin
					held[i] = 1'b0;
					res.push_back('{itw_pkg::ID_W'(i), 1'b0});
				end
			end
			if (res.size() > 0)
				res[res.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic int pace();
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic issue(input logic c, input logic [itw_pkg::ID_W-1:0] id,
			input int n_typed, input logic [itw_pkg::ID_W-1:0] first_id,
			input logic [itw_pkg::ID_W-1:0] second_id);
		expiry_t got[$];
		int gap;
		gap = pace();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= itw_pkg::DATA_W'(id);
		s_axis_tuser <= c;
		do @(posedge clk); while (!s_axis_tready);
		wheel_step(c, id, got);
		if (n_typed == USE_MODEL) begin
			foreach (got[i])
				due_expiries.push_back(got[i]);
		end else begin
			if (n_typed >= 1)
				due_expiries.push_back('{first_id, n_typed == 1});
			if (n_typed == 2)
				due_expiries.push_back('{second_id, 1'b1});
		end
		reqs_sent++;
		if (c == itw_pkg::CMD_TICK) begin
			ticks++;
		end else begin
			touches++;
			recent_ids.push_back(id);
			if (recent_ids.size() > 8)
				void'(recent_ids.pop_front());
		end
		if (got.size() > widest_burst)
			widest_burst = got.size();
	endtask

	// every id into one slot, then a full turn so one tick drains them all
	task automatic full_sweep();
		logic [itw_pkg::ID_W-1:0] order[itw_pkg::MAX_CONN];
		logic [itw_pkg::ID_W-1:0] tmp;
		int j;
		foreach (order[i])
			order[i] = itw_pkg::ID_W'(i);
		for (int i = itw_pkg::MAX_CONN - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i])
			issue(itw_pkg::CMD_TOUCH, order[i], USE_MODEL, '0, '0);
		for (int i = 0; i < itw_pkg::WHEEL_SLOTS; i++) begin
			if (i == itw_pkg::WHEEL_SLOTS - 1)
				hold_req = 1'b1;
			issue(itw_pkg::CMD_TICK, itw_pkg::ID_W'($urandom_range(0, 63)), USE_MODEL,
				'0, '0);
		end
	endtask

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// result side
	initial begin
		expiry_t want;
		int stall;
		stall = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				expiries_seen++;
				if (due_expiries.size() == 0) begin
					$error("unexpected result: expired_id %0d last %0d",
						m_axis_tdata[itw_pkg::ID_W-1:0], m_axis_tlast);
					errors++;
				end else begin
					want = due_expiries.pop_front();
					if (m_axis_tdata[itw_pkg::ID_W-1:0] !== want.id) begin
						$error("expired_id: expected %0d, actual %0d", want.id,
							m_axis_tdata[itw_pkg::ID_W-1:0]);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
						errors++;
					end
				end
				stall = pace();
			end
			if (hold_req) begin
				hold_req = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// request side
	initial begin
		int r;
		logic [itw_pkg::ID_W-1:0] id;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = itw_pkg::CMD_TOUCH;
		errors = 0;
		reqs_sent = 0;
		touches = 0;
		ticks = 0;
		expiries_seen = 0;
		widest_burst = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		wheel_pos = '0;
		foreach (held[i]) begin
			held[i] = 1'b0;
			held_slot[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			issue(plan[i].cmd, plan[i].id, plan[i].n_typed, plan[i].first_id,
				plan[i].second_id);

		full_sweep();
		while (reqs_sent < PLAN_ROWS + RANDOM_REQS) begin
			if (reqs_sent % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 30) begin
				issue(itw_pkg::CMD_TICK, itw_pkg::ID_W'($urandom_range(0, 63)), USE_MODEL,
					'0, '0);
			end else begin
				if (r < 50 && recent_ids.size() > 0)
					id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
				else if (r < 58)
					id = $urandom_range(0, 1) ? itw_pkg::ID_W'(itw_pkg::MAX_CONN - 1) : '0;
				else
					id = itw_pkg::ID_W'($urandom_range(0, itw_pkg::MAX_CONN - 1));
				issue(itw_pkg::CMD_TOUCH, id, USE_MODEL, '0, '0);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (due_expiries.size() != 0)
			@(posedge clk);
		repeat (itw_pkg::MAX_CONN + 16) @(posedge clk);

		$display("run covered %0d touches and %0d ticks; %0d ids expired",
			touches, ticks, expiries_seen);
		$display("up to %0d ids expired on one tick, with a long receiver hold",
			widest_burst);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
